// ===== sv/wps_pkg.sv =====
// Shared types and constants of the waypoint path subdivider.
`timescale 1ns / 1ps
package wps_pkg;

   localparam int COORD_W = 32;
   localparam int GAP_W   = 16;
   localparam int MAG_W   = 35;
   localparam int ROOT_W  = 36;
   localparam int SQ_W    = 2 * ROOT_W;
   localparam int DIV_NW  = 36;
   localparam int DIV_DW  = 16;
   localparam int NUM_AX  = 3;

   localparam logic [GAP_W-1:0] GAP_RESET = 16'd1500;

   typedef struct packed {
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic [COORD_W-1:0] sz;
      logic [COORD_W-1:0] ex;
      logic [COORD_W-1:0] ey;
      logic [COORD_W-1:0] ez;
   } seg_type;

endpackage

// ===== sv/wps_fifo.sv =====
// Two-entry segment queue between the front and back parts.
`timescale 1ns / 1ps
module wps_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  wps_pkg::seg_type din,
   input  logic            pop,
   output wps_pkg::seg_type dout,
   output logic            full,
   output logic            empty
);
   import wps_pkg::*;

   seg_type    mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= din;
      end
   end

   assign dout  = mem[rd_ptr_ff];
   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
endmodule

// ===== sv/wps_front.sv =====
// Front part: takes waypoints, keeps the previous one and queues segments.
`timescale 1ns / 1ps
module wps_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [wps_pkg::COORD_W-1:0] req_wp_x,
   input  logic [wps_pkg::COORD_W-1:0] req_wp_y,
   input  logic [wps_pkg::COORD_W-1:0] req_wp_z,
   input  logic                        req_route_start,
   input  logic                        q_full,
   output logic                        q_push,
   output wps_pkg::seg_type            q_din
);
   import wps_pkg::*;

   logic [COORD_W-1:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic               have_prev_ff;
   logic               accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // A route start, or a waypoint with nothing before it, only seeds the segment.
   assign q_push = accept && !req_route_start && have_prev_ff;

   always_comb begin
      q_din.sx = prev_x_ff;
      q_din.sy = prev_y_ff;
      q_din.sz = prev_z_ff;
      q_din.ex = req_wp_x;
      q_din.ey = req_wp_y;
      q_din.ez = req_wp_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
         have_prev_ff <= 1'b0;
      end else if (accept) begin
         prev_x_ff    <= req_wp_x;
         prev_y_ff    <= req_wp_y;
         prev_z_ff    <= req_wp_z;
         have_prev_ff <= 1'b1;
      end
   end
endmodule

// ===== sv/wps_hyp.sv =====
// Serial unit for floor(sqrt(a*a + b*b)): shift-add squares, then a bit-pair root.
`timescale 1ns / 1ps
module wps_hyp (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [wps_pkg::MAG_W-1:0]  op_a,
   input  logic [wps_pkg::MAG_W-1:0]  op_b,
   output logic                       done,
   output logic [wps_pkg::ROOT_W-1:0] root
);
   import wps_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_SQA  = 2'd1;
   localparam logic [1:0] PH_SQB  = 2'd2;
   localparam logic [1:0] PH_ROOT = 2'd3;
   localparam int CNT_W = $clog2(ROOT_W);

   logic [1:0]        phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SQ_W-1:0]   mcand_ff, mcand_in;
   logic [MAG_W-1:0]  mplier_ff, mplier_in;
   logic [MAG_W-1:0]  b_ff, b_in;
   logic [SQ_W-1:0]   acc_ff, acc_in;
   logic [ROOT_W+1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic              done_ff, done_in;
   logic [ROOT_W+1:0] rem_sh, trial;

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      done_in   = 1'b0;
      rem_sh    = {rem_ff[ROOT_W-1:0], acc_ff[SQ_W-1:SQ_W-2]};
      trial     = {root_ff, 2'b01};
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               mcand_in  = SQ_W'(op_a);
               mplier_in = op_a;
               b_in      = op_b;
               acc_in    = '0;
               cnt_in    = '0;
               phase_in  = PH_SQA;
            end
         end
         PH_SQA, PH_SQB: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAG_W - 1)) begin
               cnt_in = '0;
               if (phase_ff == PH_SQA) begin
                  mcand_in  = SQ_W'(b_ff);
                  mplier_in = b_ff;
                  phase_in  = PH_SQB;
               end else begin
                  rem_in   = '0;
                  root_in  = '0;
                  phase_in = PH_ROOT;
               end
            end
         end
         PH_ROOT: begin
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            acc_in = acc_ff << 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      b_ff      <= b_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ===== sv/wps_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wps_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [wps_pkg::DIV_NW-1:0] num,
   input  logic [wps_pkg::DIV_DW-1:0] den,
   output logic                       done,
   output logic [wps_pkg::DIV_NW-1:0] quot,
   output logic [wps_pkg::DIV_DW-1:0] rem
);
   import wps_pkg::*;

   localparam int CNT_W = $clog2(DIV_NW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_NW-1:0] num_ff, num_in;
   logic [DIV_DW-1:0] den_ff, den_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW:0]   r2;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      r2      = {rem_ff, num_ff[DIV_NW-1]};
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            cnt_in  = '0;
            num_in  = num;
            den_in  = den;
            rem_in  = '0;
         end
      end else begin
         if (r2 >= {1'b0, den_ff}) begin
            rem_in = DIV_DW'(r2 - {1'b0, den_ff});
            num_in = {num_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = r2[DIV_DW-1:0];
            num_in = {num_ff[DIV_NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = num_ff;
   assign rem  = rem_ff;
endmodule

// ===== sv/wps_back.sv =====
// Back part: segment length, point count, per-axis steps and point output.
`timescale 1ns / 1ps
module wps_back #(
   parameter int MAX_INTERP = 63
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [wps_pkg::GAP_W-1:0]   gap_size,
   input  logic                        q_empty,
   input  wps_pkg::seg_type            q_dout,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [wps_pkg::COORD_W-1:0] rsp_pt_x,
   output logic [wps_pkg::COORD_W-1:0] rsp_pt_y,
   output logic [wps_pkg::COORD_W-1:0] rsp_pt_z,
   output logic                        rsp_is_waypoint,
   output logic                        rsp_last,
   output logic                        rsp_clipped
);
   import wps_pkg::*;

   localparam int CW = $clog2(MAX_INTERP + 2);
   localparam int QW = COORD_W + 2;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_HYP1 = 3'd1;
   localparam logic [2:0] ST_HYP2 = 3'd2;
   localparam logic [2:0] ST_DIVN = 3'd3;
   localparam logic [2:0] ST_DIVA = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [COORD_W-1:0]  s_ff [NUM_AX];
   logic [COORD_W-1:0]  s_in [NUM_AX];
   logic [COORD_W-1:0]  e_ff [NUM_AX];
   logic [COORD_W-1:0]  e_in [NUM_AX];
   logic [COORD_W:0]    mag_ff [NUM_AX];
   logic [COORD_W:0]    mag_in [NUM_AX];
   logic                neg_ff [NUM_AX];
   logic                neg_in [NUM_AX];
   logic [QW-1:0]       q0_ff [NUM_AX];
   logic [QW-1:0]       q0_in [NUM_AX];
   logic [DIV_DW-1:0]   r0_ff [NUM_AX];
   logic [DIV_DW-1:0]   r0_in [NUM_AX];
   logic [QW-1:0]       qa_ff [NUM_AX];
   logic [QW-1:0]       qa_in [NUM_AX];
   logic [DIV_DW-1:0]   ra_ff [NUM_AX];
   logic [DIV_DW-1:0]   ra_in [NUM_AX];
   logic [QW-1:0]       qn [NUM_AX];
   logic [DIV_DW-1:0]   rn [NUM_AX];
   logic [COORD_W-1:0]  coord [NUM_AX];
   logic [DIV_DW:0]     rsum;
   logic [COORD_W:0]    diff;
   logic [QW-1:0]       sq;

   logic [1:0]          ax_ff, ax_in;
   logic [CW-1:0]       n_ff, n_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                clip_ff, clip_in;
   logic [CW-1:0]       m_val;
   logic [GAP_W-1:0]    gap_eff;

   logic                hyp_go_ff, hyp_go_in;
   logic [MAG_W-1:0]    hyp_a_ff, hyp_a_in, hyp_b_ff, hyp_b_in;
   logic                hyp_done;
   logic [ROOT_W-1:0]   hyp_root;
   logic                div_go_ff, div_go_in;
   logic [DIV_NW-1:0]   div_num_ff, div_num_in;
   logic [DIV_DW-1:0]   div_den_ff, div_den_in;
   logic                div_done;
   logic [DIV_NW-1:0]   div_q;
   logic [DIV_DW-1:0]   div_r;

   logic                out_v_ff, out_v_in;
   logic [COORD_W-1:0]  out_x_ff, out_x_in, out_y_ff, out_y_in, out_z_ff, out_z_in;
   logic                out_wp_ff, out_wp_in, out_clip_ff, out_clip_in;
   logic                out_load;

   wps_hyp u_hyp (
      .clock (clock),
      .reset (reset),
      .start (hyp_go_ff),
      .op_a  (hyp_a_ff),
      .op_b  (hyp_b_ff),
      .done  (hyp_done),
      .root  (hyp_root)
   );

   wps_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quot  (div_q),
      .rem   (div_r)
   );

   assign gap_eff  = (gap_size == '0) ? GAP_W'(1) : gap_size;
   assign m_val    = n_ff + 1'b1;
   assign out_load = !out_v_ff || !rsp_stall;

   // Point i on an axis is |d|*i/m kept as quotient and remainder, stepped by |d|/m.
   always_comb begin
      for (int a = 0; a < NUM_AX; a++) begin
         rsum = {1'b0, ra_ff[a]} + {1'b0, r0_ff[a]};
         if (rsum >= (DIV_DW + 1)'(m_val)) begin
            rn[a] = DIV_DW'(rsum - (DIV_DW + 1)'(m_val));
            qn[a] = qa_ff[a] + q0_ff[a] + QW'(1);
         end else begin
            rn[a] = rsum[DIV_DW-1:0];
            qn[a] = qa_ff[a] + q0_ff[a];
         end
         sq       = neg_ff[a] ? (QW'(0) - qn[a]) : qn[a];
         coord[a] = COORD_W'({{(QW - COORD_W){s_ff[a][COORD_W-1]}}, s_ff[a]} + sq);
      end
   end

   always_comb begin
      state_in    = state_ff;
      ax_in       = ax_ff;
      n_in        = n_ff;
      cnt_in      = cnt_ff;
      clip_in     = clip_ff;
      hyp_go_in   = 1'b0;
      hyp_a_in    = hyp_a_ff;
      hyp_b_in    = hyp_b_ff;
      div_go_in   = 1'b0;
      div_num_in  = div_num_ff;
      div_den_in  = div_den_ff;
      out_v_in    = out_v_ff && rsp_stall;
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      out_z_in    = out_z_ff;
      out_wp_in   = out_wp_ff;
      out_clip_in = out_clip_ff;
      q_pop       = 1'b0;
      diff        = '0;
      for (int a = 0; a < NUM_AX; a++) begin
         s_in[a]   = s_ff[a];
         e_in[a]   = e_ff[a];
         mag_in[a] = mag_ff[a];
         neg_in[a] = neg_ff[a];
         q0_in[a]  = q0_ff[a];
         r0_in[a]  = r0_ff[a];
         qa_in[a]  = qa_ff[a];
         ra_in[a]  = ra_ff[a];
      end
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               s_in[0] = q_dout.sx;
               s_in[1] = q_dout.sy;
               s_in[2] = q_dout.sz;
               e_in[0] = q_dout.ex;
               e_in[1] = q_dout.ey;
               e_in[2] = q_dout.ez;
               for (int a = 0; a < NUM_AX; a++) begin
                  diff = {e_in[a][COORD_W-1], e_in[a]} - {s_in[a][COORD_W-1], s_in[a]};
                  neg_in[a] = diff[COORD_W];
                  mag_in[a] = diff[COORD_W] ? ((COORD_W + 1)'(0) - diff) : diff;
               end
               hyp_a_in  = MAG_W'(mag_in[0]);
               hyp_b_in  = MAG_W'(mag_in[1]);
               hyp_go_in = 1'b1;
               state_in  = ST_HYP1;
            end
         end
         ST_HYP1: begin
            if (hyp_done) begin
               hyp_a_in  = hyp_root[MAG_W-1:0];
               hyp_b_in  = MAG_W'(mag_ff[2]);
               hyp_go_in = 1'b1;
               state_in  = ST_HYP2;
            end
         end
         ST_HYP2: begin
            if (hyp_done) begin
               div_num_in = DIV_NW'(hyp_root);
               div_den_in = DIV_DW'(gap_eff);
               div_go_in  = 1'b1;
               state_in   = ST_DIVN;
            end
         end
         ST_DIVN: begin
            if (div_done) begin
               if (div_q > DIV_NW'(MAX_INTERP)) begin
                  n_in    = CW'(MAX_INTERP);
                  clip_in = 1'b1;
               end else begin
                  n_in    = div_q[CW-1:0];
                  clip_in = 1'b0;
               end
               div_num_in = DIV_NW'(mag_ff[0]);
               div_den_in = DIV_DW'(n_in + 1'b1);
               div_go_in  = 1'b1;
               ax_in      = 2'd0;
               state_in   = ST_DIVA;
            end
         end
         ST_DIVA: begin
            if (div_done) begin
               q0_in[ax_ff] = QW'(div_q);
               r0_in[ax_ff] = div_r;
               if (ax_ff == 2'(NUM_AX - 1)) begin
                  for (int a = 0; a < NUM_AX; a++) begin
                     qa_in[a] = '0;
                     ra_in[a] = '0;
                  end
                  cnt_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  ax_in      = ax_ff + 1'b1;
                  div_num_in = DIV_NW'(mag_ff[ax_in]);
                  div_go_in  = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               out_v_in    = 1'b1;
               out_clip_in = clip_ff;
               if (cnt_ff == n_ff) begin
                  out_x_in  = e_ff[0];
                  out_y_in  = e_ff[1];
                  out_z_in  = e_ff[2];
                  out_wp_in = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  out_x_in  = coord[0];
                  out_y_in  = coord[1];
                  out_z_in  = coord[2];
                  out_wp_in = 1'b0;
                  for (int a = 0; a < NUM_AX; a++) begin
                     qa_in[a] = qn[a];
                     ra_in[a] = rn[a];
                  end
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         hyp_go_ff <= 1'b0;
         div_go_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         hyp_go_ff <= hyp_go_in;
         div_go_ff <= div_go_in;
         out_v_ff  <= out_v_in;
      end
      ax_ff       <= ax_in;
      n_ff        <= n_in;
      cnt_ff      <= cnt_in;
      clip_ff     <= clip_in;
      hyp_a_ff    <= hyp_a_in;
      hyp_b_ff    <= hyp_b_in;
      div_num_ff  <= div_num_in;
      div_den_ff  <= div_den_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_z_ff    <= out_z_in;
      out_wp_ff   <= out_wp_in;
      out_clip_ff <= out_clip_in;
      for (int a = 0; a < NUM_AX; a++) begin
         s_ff[a]   <= s_in[a];
         e_ff[a]   <= e_in[a];
         mag_ff[a] <= mag_in[a];
         neg_ff[a] <= neg_in[a];
         q0_ff[a]  <= q0_in[a];
         r0_ff[a]  <= r0_in[a];
         qa_ff[a]  <= qa_in[a];
         ra_ff[a]  <= ra_in[a];
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_pt_x        = out_x_ff;
   assign rsp_pt_y        = out_y_ff;
   assign rsp_pt_z        = out_z_ff;
   assign rsp_is_waypoint = out_wp_ff;
   assign rsp_last        = out_wp_ff;
   assign rsp_clipped     = out_clip_ff;
endmodule

// ===== sv/waypoint_path_subdivider.sv =====
// Top level of the waypoint path subdivider.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+----------------------------------------
//  req     | in        | req_valid/req_stall  | wp_x, wp_y, wp_z, route_start
//  rsp     | out       | rsp_valid/rsp_stall  | pt_x, pt_y, pt_z, is_waypoint, last,
//          |           |                      | clipped
//  csr     | in        | csr_we               | csr_wdata (gap_size)
//
// A waypoint that closes a segment occupies the back part while it takes the segment from
// the queue, runs the one serial length unit twice (two shift-add squares and a bit-pair
// root per pass) and runs four passes of the serial divider (point count, then one step
// size per axis), each pass with a start and done handoff, then gives one point per cycle
// for the n + 1 results while the receiver does not stall, where n is the number of
// interpolated points.
// The front part takes a request each cycle while the two-entry segment queue has room;
// route starts never enter the queue. Reset is synchronous and sets gap_size to 1500
// and forgets the previous waypoint. A stalled result holds in the output register.
module waypoint_path_subdivider #(
   parameter int MAX_INTERP = 63
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [wps_pkg::COORD_W-1:0] req_wp_x,
   input  logic [wps_pkg::COORD_W-1:0] req_wp_y,
   input  logic [wps_pkg::COORD_W-1:0] req_wp_z,
   input  logic                        req_route_start,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [wps_pkg::COORD_W-1:0] rsp_pt_x,
   output logic [wps_pkg::COORD_W-1:0] rsp_pt_y,
   output logic [wps_pkg::COORD_W-1:0] rsp_pt_z,
   output logic                        rsp_is_waypoint,
   output logic                        rsp_last,
   output logic                        rsp_clipped,
   input  logic                        csr_we,
   input  logic [wps_pkg::GAP_W-1:0]   csr_wdata
);
   import wps_pkg::*;

   logic [GAP_W-1:0] gap_ff;
   logic             q_full, q_empty, q_push, q_pop;
   seg_type          q_din, q_dout;

   // The spacing register; a zero write is treated as one by the back part.
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= GAP_RESET;
      end else if (csr_we) begin
         gap_ff <= csr_wdata;
      end
   end

   // The front part keeps the previous waypoint and turns each request that
   // closes a segment into one queue entry.
   wps_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_wp_x        (req_wp_x),
      .req_wp_y        (req_wp_y),
      .req_wp_z        (req_wp_z),
      .req_route_start (req_route_start),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_din           (q_din)
   );

   wps_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_dout),
      .full  (q_full),
      .empty (q_empty)
   );

   // The back part measures each segment and streams its points out.
   wps_back #(
      .MAX_INTERP (MAX_INTERP)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .gap_size        (gap_ff),
      .q_empty         (q_empty),
      .q_dout          (q_dout),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pt_x        (rsp_pt_x),
      .rsp_pt_y        (rsp_pt_y),
      .rsp_pt_z        (rsp_pt_z),
      .rsp_is_waypoint (rsp_is_waypoint),
      .rsp_last        (rsp_last),
      .rsp_clipped     (rsp_clipped)
   );
endmodule
